/* hw/rtl/imu_angle_frame_parser_defines.svh */
// Assertion macros for the angle frame parser.
`ifndef IMU_ANGLE_FRAME_PARSER_DEFINES_SVH
`define IMU_ANGLE_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define IMUAFP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imuafp assertion failed");
`define IMUAFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imuafp assertion failed");
`else
`define IMUAFP_ASSERT_SAME(label, ante, cons)
`define IMUAFP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hw/rtl/imuafp_pkg.sv */
package imuafp_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] ANGLE_TYPE  = 8'h53;
	localparam int         FRAME_LEN   = 11;
	localparam int         POS_W       = $clog2(FRAME_LEN);
	localparam logic [POS_W-1:0] POS_FIRST = '0;
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);
	localparam int         ELAPSED_W   = 17;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef struct packed {
		logic               updated;
		logic               failed;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} frame_evt_t;

endpackage

/* hw/rtl/imuafp_if.sv */
interface imuafp_req_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source (output valid, command, data_byte, input ready);
	modport sink   (input valid, command, data_byte, output ready);
endinterface

interface imuafp_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               angles_updated;
	logic               checksum_failed;
	logic               stale;
	logic [31:0]        bytes_seen;
	logic [31:0]        frames_seen;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, angles_updated,
		checksum_failed, stale, bytes_seen, frames_seen, input ready);
	modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, angles_updated,
		checksum_failed, stale, bytes_seen, frames_seen, output ready);
endinterface

/* hw/rtl/imuafp_frame.sv */
module imuafp_frame (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_en,
	input  logic [7:0]              data_byte,
	output imuafp_pkg::frame_evt_t  evt
);

	logic [imuafp_pkg::POS_W-1:0] pos_q;
	logic [7:0]                   sum_q;
	logic [7:0]                   frame_q [1:7];
	logic                         take;
	logic                         last;
	logic                         sum_ok;

	assign take   = byte_en &&
		!(pos_q == imuafp_pkg::POS_FIRST && data_byte != imuafp_pkg::HEADER_BYTE);
	assign last   = pos_q == imuafp_pkg::POS_LAST;
	assign sum_ok = sum_q == data_byte;

	always_comb begin
		evt.updated = take && last && sum_ok && frame_q[1] == imuafp_pkg::ANGLE_TYPE;
		evt.failed  = take && last && !sum_ok;
		evt.roll    = {frame_q[3], frame_q[2]};
		evt.pitch   = {frame_q[5], frame_q[4]};
		evt.yaw     = {frame_q[7], frame_q[6]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= imuafp_pkg::POS_FIRST;
			sum_q <= '0;
		end else if (take) begin
			if (last) begin
				pos_q <= imuafp_pkg::POS_FIRST;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= (pos_q == imuafp_pkg::POS_FIRST) ? data_byte : sum_q + data_byte;
			end
		end
	end

	// hold the type and angle bytes of the frame in progress
	always_ff @(posedge clk) begin
		for (int i = 1; i <= 7; i++) begin
			if (take && pos_q == imuafp_pkg::POS_W'(i)) begin
				frame_q[i] <= data_byte;
			end
		end
	end

endmodule

/* hw/rtl/imu_angle_frame_parser.sv */
// Channel  Dir  Payload
// req      in   command, data_byte
// rsp      out  roll/pitch/yaw_angle, angles_updated, checksum_failed, stale,
//               bytes_seen, frames_seen
// timeout  in   timeout_ms_we, timeout_ms_wdata
//
// One request is taken per cycle while req.ready is high; its response
// appears in the output register the next cycle.
// The running sum and frame position advance once per accepted frame byte.
// A stalled response holds the output register; req.ready is low only while a
// response waits and rsp.ready is low.
// Reset clears frame position, sum, angles, counters and sets timeout to 100.
`include "imu_angle_frame_parser_defines.svh"

module imu_angle_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	imuafp_req_if.sink         req,
	imuafp_rsp_if.source       rsp,
	input  logic               timeout_ms_we,
	input  logic [15:0]        timeout_ms_wdata
);

	logic [15:0]                        timeout_q;
	logic                               rsp_valid_q;
	logic signed [15:0]                 roll_q;
	logic signed [15:0]                 pitch_q;
	logic signed [15:0]                 yaw_q;
	logic                               updated_q;
	logic                               failed_q;
	logic                               stale_q;
	logic [imuafp_pkg::ELAPSED_W-1:0]   elapsed_q;
	logic [31:0]                        bytes_q;
	logic [31:0]                        frames_q;

	logic                               accept;
	logic                               byte_en;
	logic                               tick_en;
	imuafp_pkg::frame_evt_t             evt;
	logic [imuafp_pkg::ELAPSED_W-1:0]   elapsed_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign byte_en   = accept && !req.command;
	assign tick_en   = accept && req.command;

	imuafp_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_en),
		.data_byte (req.data_byte),
		.evt       (evt)
	);

	always_comb begin
		elapsed_d = elapsed_q;
		if (tick_en) begin
			if (elapsed_q != imuafp_pkg::ELAPSED_MAX) begin
				elapsed_d = elapsed_q + 1'b1;
			end
		end else if (evt.updated) begin
			elapsed_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= imuafp_pkg::TIMEOUT_RESET;
		end else if (timeout_ms_we) begin
			timeout_q <= timeout_ms_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			roll_q      <= '0;
			pitch_q     <= '0;
			yaw_q       <= '0;
			updated_q   <= 1'b0;
			failed_q    <= 1'b0;
			stale_q     <= 1'b0;
			elapsed_q   <= '0;
			bytes_q     <= '0;
			frames_q    <= '0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				updated_q <= evt.updated;
				failed_q  <= evt.failed;
				stale_q   <= elapsed_d > {1'b0, timeout_q};
				elapsed_q <= elapsed_d;
				if (byte_en) begin
					bytes_q <= bytes_q + 1'b1;
				end
				if (evt.updated) begin
					roll_q   <= evt.roll;
					pitch_q  <= evt.pitch;
					yaw_q    <= evt.yaw;
					frames_q <= frames_q + 1'b1;
				end
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.roll_angle      = roll_q;
	assign rsp.pitch_angle     = pitch_q;
	assign rsp.yaw_angle       = yaw_q;
	assign rsp.angles_updated  = updated_q;
	assign rsp.checksum_failed = failed_q;
	assign rsp.stale           = stale_q;
	assign rsp.bytes_seen      = bytes_q;
	assign rsp.frames_seen     = frames_q;

	`IMUAFP_ASSERT_SAME(a_flags_exclusive, rsp_valid_q, !(updated_q && failed_q))
	`IMUAFP_ASSERT_SAME(a_fresh_not_stale, rsp_valid_q && updated_q, !stale_q)
	`IMUAFP_ASSERT_NEXT(a_frame_count, accept && evt.updated, frames_q == $past(frames_q) + 32'd1)
	`IMUAFP_ASSERT_NEXT(a_tick_no_byte, tick_en, bytes_q == $past(bytes_q))

endmodule

/* tb/imu_angle_frame_parser_tb.sv */
`timescale 1ns / 100ps

module imu_angle_frame_parser_tb;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} imu_req_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               updated;
		logic               failed;
		logic               stale;
		logic [31:0]        byte_count;
		logic [31:0]        frame_count;
	} angle_report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        timeout_ms_we;
	logic [15:0] timeout_ms_wdata;

	imuafp_req_if req_if ();
	imuafp_rsp_if rsp_if ();

	imu_angle_frame_parser uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req              (req_if),
		.rsp              (rsp_if),
		.timeout_ms_we    (timeout_ms_we),
		.timeout_ms_wdata (timeout_ms_wdata)
	);

	always #5 clk = ~clk;

	imu_req_t      requests_to_send[$];
	angle_report_t reports_due[$];

	logic [imuafp_pkg::POS_W-1:0]     hunt_pos       = imuafp_pkg::POS_FIRST;
	logic [7:0]                       frame_buf[imuafp_pkg::FRAME_LEN] = '{default: 8'h00};
	logic [7:0]                       sum_acc        = 8'h00;
	logic signed [15:0]               roll_q         = '0;
	logic signed [15:0]               pitch_q        = '0;
	logic signed [15:0]               yaw_q          = '0;
	logic [imuafp_pkg::ELAPSED_W-1:0] ms_since_frame = '0;
	logic [31:0]                      byte_total     = '0;
	logic [31:0]                      frame_total    = '0;
	logic [15:0]                      timeout_q      = imuafp_pkg::TIMEOUT_RESET;

	int req_gap_pct;
	int rsp_stall_pct;
	int gap_left;
	int stall_left;
	int requests_queued;
	int responses_checked;
	int mismatch_count;
	int good_frames_due;
	int sum_errors_due;
	int stale_due;
	int ticks_due;

	function automatic void parse_request(input imu_req_t r);
		angle_report_t rep;
		logic          upd;
		logic          bad;
		logic [7:0]    b;
		upd = 1'b0;
		bad = 1'b0;
		b = r.data_byte;
		if (r.command == CMD_TICK) begin
			ticks_due++;
			if (ms_since_frame != imuafp_pkg::ELAPSED_MAX)
				ms_since_frame = ms_since_frame + 1'b1;
		end else begin
			byte_total = byte_total + 1;
			if (!(hunt_pos == imuafp_pkg::POS_FIRST && b != imuafp_pkg::HEADER_BYTE)) begin
				frame_buf[hunt_pos] = b;
				if (hunt_pos < imuafp_pkg::POS_LAST) begin
					sum_acc = (hunt_pos == imuafp_pkg::POS_FIRST) ? b : sum_acc + b;
					hunt_pos = hunt_pos + 1'b1;
				end else begin
					hunt_pos = imuafp_pkg::POS_FIRST;
					if (sum_acc != b) begin
						bad = 1'b1;
					end else if (frame_buf[1] == imuafp_pkg::ANGLE_TYPE) begin
						roll_q = {frame_buf[3], frame_buf[2]};
						pitch_q = {frame_buf[5], frame_buf[4]};
						yaw_q = {frame_buf[7], frame_buf[6]};
						ms_since_frame = '0;
						frame_total = frame_total + 1;
						upd = 1'b1;
					end
					sum_acc = 8'h00;
				end
			end
		end
		rep.roll = roll_q;
		rep.pitch = pitch_q;
		rep.yaw = yaw_q;
		rep.updated = upd;
		rep.failed = bad;
		rep.stale = ms_since_frame > {1'b0, timeout_q};
		rep.byte_count = byte_total;
		rep.frame_count = frame_total;
		good_frames_due += upd;
		sum_errors_due += bad;
		stale_due += rep.stale;
		reports_due.push_back(rep);
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH at %0t, response %0d: %s", $time, responses_checked, msg);
	endtask

	task automatic check_response();
		angle_report_t want;
		responses_checked++;
		if (reports_due.size() == 0) begin
			note_mismatch("response with no request outstanding");
			return;
		end
		want = reports_due.pop_front();
		if (rsp_if.roll_angle !== want.roll)
			note_mismatch($sformatf("roll_angle %0d, want %0d", rsp_if.roll_angle, want.roll));
		if (rsp_if.pitch_angle !== want.pitch)
			note_mismatch($sformatf("pitch_angle %0d, want %0d", rsp_if.pitch_angle, want.pitch));
		if (rsp_if.yaw_angle !== want.yaw)
			note_mismatch($sformatf("yaw_angle %0d, want %0d", rsp_if.yaw_angle, want.yaw));
		if (rsp_if.angles_updated !== want.updated)
			note_mismatch($sformatf("angles_updated %b, want %b",
				rsp_if.angles_updated, want.updated));
		if (rsp_if.checksum_failed !== want.failed)
			note_mismatch($sformatf("checksum_failed %b, want %b",
				rsp_if.checksum_failed, want.failed));
		if (rsp_if.stale !== want.stale)
			note_mismatch($sformatf("stale %b, want %b", rsp_if.stale, want.stale));
		if (rsp_if.bytes_seen !== want.byte_count)
			note_mismatch($sformatf("bytes_seen %0d, want %0d",
				rsp_if.bytes_seen, want.byte_count));
		if (rsp_if.frames_seen !== want.frame_count)
			note_mismatch($sformatf("frames_seen %0d, want %0d",
				rsp_if.frames_seen, want.frame_count));
	endtask

	always @(posedge clk) begin : req_driver
		if (arst_n) begin
			if (timeout_ms_we)
				timeout_q = timeout_ms_wdata;
			if (req_if.valid && req_if.ready)
				parse_request(requests_to_send.pop_front());
			if (!(req_if.valid && !req_if.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (requests_to_send.size() == 0) begin
					req_if.valid <= 1'b0;
				end else if (req_gap_pct > 0 && $urandom_range(99) < req_gap_pct) begin
					gap_left = $urandom_range(1, 17) - 1;
					req_if.valid <= 1'b0;
				end else begin
					req_if.valid <= 1'b1;
					req_if.command <= requests_to_send[0].command;
					req_if.data_byte <= requests_to_send[0].data_byte;
				end
			end
		end else begin
			req_if.valid <= 1'b0;
			req_if.command <= CMD_BYTE;
			req_if.data_byte <= 8'h00;
		end
	end

	always @(posedge clk) begin : rsp_monitor
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				check_response();
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (rsp_stall_pct > 0 && $urandom_range(99) < rsp_stall_pct) begin
				stall_left = $urandom_range(1, 17) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end else begin
			rsp_if.ready <= 1'b0;
		end
	end

	function automatic void push_request(input logic cmd, input logic [7:0] b);
		imu_req_t r;
		r.command = cmd;
		r.data_byte = b;
		requests_to_send.push_back(r);
		requests_queued++;
	endfunction

	function automatic void push_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_request(CMD_TICK, 8'($urandom));
	endfunction

	function automatic void queue_frame(input logic [7:0] kind, input logic [15:0] r,
		input logic [15:0] p, input logic [15:0] y, input logic [7:0] tail_a,
		input logic [7:0] tail_b, input bit bad_sum);
		logic [7:0] fb[imuafp_pkg::FRAME_LEN];
		logic [7:0] s;
		fb[0] = imuafp_pkg::HEADER_BYTE;
		fb[1] = kind;
		fb[2] = r[7:0];
		fb[3] = r[15:8];
		fb[4] = p[7:0];
		fb[5] = p[15:8];
		fb[6] = y[7:0];
		fb[7] = y[15:8];
		fb[8] = tail_a;
		fb[9] = tail_b;
		s = 8'h00;
		for (int i = 0; i < imuafp_pkg::FRAME_LEN - 1; i++)
			s = s + fb[i];
		fb[imuafp_pkg::FRAME_LEN-1] = bad_sum ? (s ^ 8'($urandom_range(1, 255))) : s;
		for (int i = 0; i < imuafp_pkg::FRAME_LEN; i++)
			push_request(CMD_BYTE, fb[i]);
	endfunction

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (requests_to_send.size() != 0 || reports_due.size() != 0 || req_if.valid);
	endtask

	task automatic set_timeout(input logic [15:0] v);
		wait_drained();
		repeat (2) @(negedge clk);
		@(posedge clk);
		timeout_ms_we <= 1'b1;
		timeout_ms_wdata <= v;
		@(posedge clk);
		timeout_ms_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_mixed(input int n_items);
		int         goal;
		int         pick;
		logic [7:0] kind;
		goal = requests_queued + n_items;
		while (requests_queued < goal) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				queue_frame(imuafp_pkg::ANGLE_TYPE, pick_angle(), pick_angle(), pick_angle(),
					8'($urandom), 8'($urandom), 1'b0);
			end else if (pick < 65) begin
				do kind = 8'($urandom); while (kind == imuafp_pkg::ANGLE_TYPE);
				queue_frame(kind, pick_angle(), pick_angle(), pick_angle(),
					8'($urandom), 8'($urandom), 1'b0);
			end else if (pick < 75) begin
				queue_frame(imuafp_pkg::ANGLE_TYPE, pick_angle(), pick_angle(), pick_angle(),
					8'($urandom), 8'($urandom), 1'b1);
			end else if (pick < 87) begin
				push_ticks($urandom_range(1, 40));
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 4)) push_request(CMD_BYTE, 8'($urandom));
			end else begin
				push_request(CMD_BYTE, imuafp_pkg::HEADER_BYTE);
				repeat ($urandom_range(1, 9)) push_request(CMD_BYTE, 8'($urandom));
			end
			if ($urandom_range(0, 40) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		timeout_ms_we = 1'b0;
		timeout_ms_wdata = 16'h0000;
		req_gap_pct = 20;
		rsp_stall_pct = 20;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray bytes, a tick, a frame carrying the header as data, a bad sum
		push_request(CMD_BYTE, 8'h00);
		push_request(CMD_BYTE, 8'hFF);
		push_ticks(1);
		queue_frame(imuafp_pkg::ANGLE_TYPE, 16'h8000, 16'h7FFF, 16'hFFFF,
			imuafp_pkg::HEADER_BYTE, 8'h00, 1'b0);
		queue_frame(imuafp_pkg::ANGLE_TYPE, 16'h0000, 16'h5555, 16'h0001,
			imuafp_pkg::HEADER_BYTE, 8'hFF, 1'b1);
		push_ticks(102);

		set_timeout(16'h0000);
		req_gap_pct = 10;
		rsp_stall_pct = 10;
		queue_mixed(300);

		// run past a short timeout, then clear the elapsed count with a frame
		set_timeout(16'd20);
		req_gap_pct = 0;
		rsp_stall_pct = 0;
		push_ticks(25);
		queue_frame(imuafp_pkg::ANGLE_TYPE, pick_angle(), pick_angle(), pick_angle(),
			8'($urandom), 8'($urandom), 1'b0);
		push_ticks(3);

		set_timeout(16'($urandom_range(1, 30)));
		req_gap_pct = 30;
		rsp_stall_pct = 5;
		queue_mixed(300);

		set_timeout(16'($urandom));
		req_gap_pct = 5;
		rsp_stall_pct = 30;
		queue_mixed(200);

		set_timeout(16'($urandom_range(2, 12)));
		req_gap_pct = 0;
		rsp_stall_pct = 0;
		queue_mixed(300);

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Checked %0d responses over %0d requests, %0d of them ticks.",
			responses_checked, requests_queued, ticks_due);
		$display("Covered %0d angle frames, %0d checksum errors and %0d stale responses.",
			good_frames_due, sum_errors_due, stale_due);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d requests unsent and %0d responses outstanding",
			requests_to_send.size(), reports_due.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
